>>> design/lkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and codes for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 4;
	localparam int OCC_W = 4;

	// command codes (code 3 is treated as a probe)
	localparam logic [1:0] CMD_GET   = 2'd0;
	localparam logic [1:0] CMD_PUT   = 2'd1;
	localparam logic [1:0] CMD_PROBE = 2'd2;

	// status codes
	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_INSERTED = 2'd2;
	localparam logic [1:0] ST_UPDATED  = 2'd3;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage : lkv_pkg
`default_nettype wire

>>> design/lkv_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_store
// Entry storage with parallel key match, LRU rank update, victim select
// and insertion. Result is combinational; state updates when step is high.
// ----------------------------------------------------------------------------
module lkv_store
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic [CAP_W-1:0] cap,
	input  wire logic             step,
	input  wire req_t             req,
	output res_t                  res
);

	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = CW + CAP_W;

	logic [KEY_W-1:0]       key_q   [MAX_ENTRIES];
	logic [VAL_W-1:0]       value_q [MAX_ENTRIES];
	logic [RW-1:0]          rank_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0]          count_q;

	logic [MAX_ENTRIES-1:0] hit_oh, evict_oh, free_oh, valid_after;
	logic                   hit, found, full, is_get, is_put, do_evict, do_insert;
	logic [RW-1:0]          hit_rank;
	logic [VAL_W-1:0]       hit_value;
	logic [KEY_W-1:0]       victim_key;
	logic [LW-1:0]          cap_w, limit, occ_w;
	logic [CW-1:0]          count_m1, count_d;

	assign is_get = (req.cmd == CMD_GET);
	assign is_put = (req.cmd == CMD_PUT);

	// first matching valid entry
	always_comb begin
		hit_oh    = '0;
		found     = 1'b0;
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (valid_q[i] && key_q[i] == req.key && !found) begin
				hit_oh[i] = 1'b1;
				found     = 1'b1;
			end
			hit_rank  = hit_rank  | (hit_oh[i] ? rank_q[i]  : '0);
			hit_value = hit_value | (hit_oh[i] ? value_q[i] : '0);
		end
		hit = found;
	end

	// effective capacity: zero acts as one, clipped to the entry count
	assign cap_w    = LW'(cap);
	assign limit    = (cap == '0) ? LW'(1)
	                : (cap_w > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : cap_w;
	assign full     = (LW'(count_q) >= limit) && (count_q != '0);
	assign count_m1 = count_q - CW'(1);
	assign do_evict = is_put && !hit && full;

	// least recent entry holds rank count-1
	always_comb begin
		victim_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			evict_oh[i] = do_evict && valid_q[i] && (CW'(rank_q[i]) == count_m1);
			victim_key  = victim_key | (evict_oh[i] ? key_q[i] : '0);
		end
	end

	assign valid_after = valid_q & ~evict_oh;

	// lowest free slot after eviction
	always_comb begin
		free_oh = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!valid_after[i] && free_oh == '0) begin
				free_oh[i] = 1'b1;
			end
		end
	end

	assign do_insert = is_put && !hit && (free_oh != '0);

	always_comb begin
		count_d = count_q;
		if (do_evict && evict_oh != '0) begin
			count_d = count_d - CW'(1);
		end
		if (do_insert) begin
			count_d = count_d + CW'(1);
		end
	end

	assign occ_w = LW'(count_d);

	always_comb begin
		res.read_value  = (is_get && hit) ? hit_value : '0;
		res.evicted     = (evict_oh != '0);
		res.evicted_key = victim_key;
		res.occupancy   = occ_w[OCC_W-1:0];
		if (is_get) begin
			res.status = hit ? ST_HIT : ST_MISS;
		end else if (is_put) begin
			res.status = hit ? ST_UPDATED : ST_INSERTED;
		end else begin
			res.status = hit ? ST_HIT : ST_MISS;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (clr) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (step) begin
			count_q <= count_d;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (hit && (is_get || is_put)) begin
					if (hit_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < hit_rank) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end else if (is_put && !hit) begin
					if (free_oh[i] && do_insert) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (evict_oh[i]) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_after[i] && do_insert) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (step && is_put) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (hit && hit_oh[i]) begin
					value_q[i] <= req.value;
				end else if (!hit && do_insert && free_oh[i]) begin
					key_q[i]   <= req.key;
					value_q[i] <= req.value;
				end
			end
		end
	end

endmodule : lkv_store
`default_nettype wire

>>> design/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the request register, and its result is
//   written to the result register for m_tdata; while m_tready holds it off, the next request waits.
// Throughput: one request per cycle while m_tready is high; lookup, rank update
//   and victim pick run in one pass between request and result registers.
// Reset: all entries invalid, occupancy zero, capacity 8, no result pending.
// A capacity write clears the store.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// capacity register write
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,
	// request stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [71:0]      s_tdata,  // command[1:0], lookup_key[33:2],
	                                        // write_value[65:34], zero pad
	// result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [71:0]           m_tdata   // status[1:0], read_value[33:2],
	                                        // evicted[34], evicted_key[66:35],
	                                        // occupancy[70:67], zero pad
);

	logic [CAP_W-1:0] cap_q;
	logic             s1_valid_q, out_valid_q;
	req_t             req_s1, req_in;
	res_t             res_c, res_q;
	logic             advance;

	// stage 1 hands its request to the store when the result slot is free
	// or is being drained this cycle
	assign advance   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready  = !s1_valid_q || advance;
	assign cfg_ready = 1'b1;

	assign req_in.cmd   = s_tdata[1:0];
	assign req_in.key   = s_tdata[33:2];
	assign req_in.value = s_tdata[65:34];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_in;
		end
	end

	lkv_store #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (cfg_valid && cfg_ready),
		.cap   (cap_q),
		.step  (advance),
		.req   (req_s1),
		.res   (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.occupancy, res_q.evicted_key, res_q.evicted,
	                   res_q.read_value, res_q.status};

endmodule : lru_key_value_cache
`default_nettype wire
